// File: rtl/core/sacr_pkg.sv
// Shared types and constants for the swept box collision pipeline.
`timescale 1ns / 1ps
`default_nettype none
package sacr_pkg;

	localparam int CW   = 32;
	localparam int SW   = 31;
	localparam int STW  = 17;
	localparam int FB   = 16;
	localparam int ETW  = 16;
	localparam int BW   = 35;
	localparam int DXW  = 33;
	localparam int DW   = 34;
	localparam int NW   = 34;
	localparam int QW   = 18;
	localparam int TW   = 20;
	localparam int PW   = 50;
	localparam int AW   = 49;
	localparam int XW   = 35;
	localparam int LANES = 4;
	localparam int IN_W  = 336;
	localparam int OUT_W = 160;

	localparam int LN_AX = 0;
	localparam int LN_BX = 1;
	localparam int LN_AY = 2;
	localparam int LN_BY = 3;

	localparam logic signed [TW-1:0] TMAX = TW'((1 << QW) - 1);
	localparam logic [STW-1:0] ONE_T = STW'(1 << FB);

	localparam logic [1:0] NRM_POS  = 2'b01;
	localparam logic [1:0] NRM_NEG  = 2'b11;
	localparam logic [1:0] NRM_NONE = 2'b00;

	typedef struct packed {
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		logic [SW-1:0]        msx;
		logic [SW-1:0]        msy;
		logic signed [CW-1:0] vx;
		logic signed [CW-1:0] vy;
		logic [STW-1:0]       st;
		logic signed [CW-1:0] ox;
		logic signed [CW-1:0] oy;
		logic [SW-1:0]        osx;
		logic [SW-1:0]        osy;
	} in_t;

	typedef struct packed {
		logic signed [CW-1:0]  px;
		logic signed [CW-1:0]  py;
		logic signed [CW-1:0]  vx;
		logic signed [CW-1:0]  vy;
		logic signed [DXW-1:0] dx;
		logic signed [DXW-1:0] dy;
		logic [DW-1:0]         dmx;
		logic [DW-1:0]         dmy;
		logic                  miss;
	} side_t;

	typedef struct packed {
		logic [DW-1:0] rem;
		logic [QW-1:0] num;
		logic          neg;
		logic          inf;
		logic          ovf;
	} lane_t;

	typedef lane_t [LANES-1:0] lanes_t;

	typedef struct packed {
		logic                 hit;
		logic [ETW-1:0]       et;
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic [1:0]           nx;
		logic [1:0]           ny;
		logic [3:0]           side;
		logic signed [CW-1:0] nvx;
		logic signed [CW-1:0] nvy;
	} res_t;

endpackage
`default_nettype wire

// File: rtl/core/sacr_front.sv
// Ray step products, grown slab bounds and divider operand setup.
`timescale 1ns / 1ps
`default_nettype none
module sacr_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire sacr_pkg::in_t  in_item,
	output logic                out_valid,
	input  wire logic           out_ready,
	output sacr_pkg::lanes_t    out_lanes,
	output sacr_pkg::side_t     out_side
);
	import sacr_pkg::*;

	logic                  vld_s1, vld_s2, rdy1, rdy2;
	logic signed [PW-1:0]  prx_c, pry_c, prx_s1, pry_s1;
	logic signed [BW-1:0]  a2x_c, b2x_c, a2y_c, b2y_c;
	logic signed [BW-1:0]  a2x_s1, b2x_s1, a2y_s1, b2y_s1;
	logic signed [CW-1:0]  px_s1, py_s1, vx_s1, vy_s1;
	logic                  vz_s1;
	logic [CW-1:0]         sx_c, sy_c;
	logic signed [DXW-1:0] dx_c, dy_c, ndx_c, ndy_c;
	logic [DW-1:0]         dmx_c, dmy_c;
	logic                  dzx_c, dzy_c;
	lanes_t                lanes_c, lanes_s2;
	side_t                 side_c, side_s2;

	function automatic lane_t mk_lane(logic signed [BW-1:0] b, logic signed [DXW-1:0] d,
			logic dz, logic [DW-1:0] dm);
		logic signed [BW-1:0] nb;
		logic [NW-1:0]        m;
		lane_t                l;
		nb = -b;
		m = b[BW-1] ? nb[NW-1:0] : b[NW-1:0];
		l.neg = dz ? b[BW-1] : (b[BW-1] ^ d[DXW-1]);
		l.inf = dz;
		l.ovf = {2'b00, m[NW-1:2]} >= dm;
		l.rem = {2'b00, m[NW-1:2]};
		l.num = {m[1:0], {FB{1'b0}}};
		return l;
	endfunction

	assign rdy2     = !vld_s2 || out_ready;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		prx_c = PW'(in_item.vx) * PW'($signed({1'b0, in_item.st}));
		pry_c = PW'(in_item.vy) * PW'($signed({1'b0, in_item.st}));
		sx_c  = {1'b0, in_item.osx} + {1'b0, in_item.msx};
		sy_c  = {1'b0, in_item.osy} + {1'b0, in_item.msy};
		a2x_c = {{2{in_item.ox[CW-1]}}, in_item.ox, 1'b0} - {3'b000, sx_c}
			- {{2{in_item.px[CW-1]}}, in_item.px, 1'b0};
		b2x_c = {{2{in_item.ox[CW-1]}}, in_item.ox, 1'b0} + {3'b000, sx_c}
			- {{2{in_item.px[CW-1]}}, in_item.px, 1'b0};
		a2y_c = {{2{in_item.oy[CW-1]}}, in_item.oy, 1'b0} - {3'b000, sy_c}
			- {{2{in_item.py[CW-1]}}, in_item.py, 1'b0};
		b2y_c = {{2{in_item.oy[CW-1]}}, in_item.oy, 1'b0} + {3'b000, sy_c}
			- {{2{in_item.py[CW-1]}}, in_item.py, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			prx_s1 <= prx_c;
			pry_s1 <= pry_c;
			a2x_s1 <= a2x_c;
			b2x_s1 <= b2x_c;
			a2y_s1 <= a2y_c;
			b2y_s1 <= b2y_c;
			px_s1  <= in_item.px;
			py_s1  <= in_item.py;
			vx_s1  <= in_item.vx;
			vy_s1  <= in_item.vy;
			vz_s1  <= (in_item.vx == '0) && (in_item.vy == '0);
		end
	end

	always_comb begin
		dx_c  = prx_s1[PW-2:FB];
		dy_c  = pry_s1[PW-2:FB];
		ndx_c = -dx_c;
		ndy_c = -dy_c;
		dmx_c = {(dx_c[DXW-1] ? ndx_c : dx_c), 1'b0};
		dmy_c = {(dy_c[DXW-1] ? ndy_c : dy_c), 1'b0};
		dzx_c = (dx_c == '0);
		dzy_c = (dy_c == '0);
		lanes_c[LN_AX] = mk_lane(a2x_s1, dx_c, dzx_c, dmx_c);
		lanes_c[LN_BX] = mk_lane(b2x_s1, dx_c, dzx_c, dmx_c);
		lanes_c[LN_AY] = mk_lane(a2y_s1, dy_c, dzy_c, dmy_c);
		lanes_c[LN_BY] = mk_lane(b2y_s1, dy_c, dzy_c, dmy_c);
		side_c.px   = px_s1;
		side_c.py   = py_s1;
		side_c.vx   = vx_s1;
		side_c.vy   = vy_s1;
		side_c.dx   = dx_c;
		side_c.dy   = dy_c;
		side_c.dmx  = dmx_c;
		side_c.dmy  = dmy_c;
		side_c.miss = vz_s1
			|| (dzx_c && (a2x_s1 == '0 || b2x_s1 == '0))
			|| (dzy_c && (a2y_s1 == '0 || b2y_s1 == '0));
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			lanes_s2 <= lanes_c;
			side_s2  <= side_c;
		end
	end

	assign out_valid = vld_s2;
	assign out_lanes = lanes_s2;
	assign out_side  = side_s2;

endmodule
`default_nettype wire

// File: rtl/core/sacr_div.sv
// Pipelined restoring divider, one quotient bit per stage on four slab lanes.
`timescale 1ns / 1ps
`default_nettype none
module sacr_div (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire sacr_pkg::lanes_t in_lanes,
	input  wire sacr_pkg::side_t  in_side,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output sacr_pkg::lanes_t     out_lanes,
	output sacr_pkg::side_t      out_side
);
	import sacr_pkg::*;

	logic [QW-1:0] vld_s;
	logic [QW:0]   rdy;
	lanes_t        lanes_s [QW];
	side_t         side_s  [QW];

	function automatic lane_t div_step(lane_t l, logic [DW-1:0] d);
		logic [DW:0] t;
		logic        ge;
		lane_t       r;
		t = {l.rem, l.num[QW-1]};
		ge = t >= {1'b0, d};
		r = l;
		r.rem = ge ? DW'(t - {1'b0, d}) : DW'(t);
		r.num = {l.num[QW-2:0], ge};
		return r;
	endfunction

	assign rdy[QW]   = out_ready;
	assign in_ready  = rdy[0];
	assign out_valid = vld_s[QW-1];
	assign out_lanes = lanes_s[QW-1];
	assign out_side  = side_s[QW-1];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic   vin;
		lanes_t lin, lnext;
		side_t  sin;

		assign rdy[k] = !vld_s[k] || rdy[k+1];

		if (k == 0) begin : g_first
			assign vin = in_valid;
			assign lin = in_lanes;
			assign sin = in_side;
		end else begin : g_rest
			assign vin = vld_s[k-1];
			assign lin = lanes_s[k-1];
			assign sin = side_s[k-1];
		end

		always_comb begin
			lnext[LN_AX] = div_step(lin[LN_AX], sin.dmx);
			lnext[LN_BX] = div_step(lin[LN_BX], sin.dmx);
			lnext[LN_AY] = div_step(lin[LN_AY], sin.dmy);
			lnext[LN_BY] = div_step(lin[LN_BY], sin.dmy);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				lanes_s[k] <= lnext;
				side_s[k]  <= sin;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/sacr_back.sv
// Slab interval merge, contact and velocity products, saturation and result register.
`timescale 1ns / 1ps
`default_nettype none
module sacr_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire sacr_pkg::lanes_t in_lanes,
	input  wire sacr_pkg::side_t  in_side,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output sacr_pkg::res_t        out_res
);
	import sacr_pkg::*;

	logic                  vld_s1, vld_s2, vld_s3, rdy1, rdy2, rdy3;
	logic signed [TW-1:0]  t_c [LANES];
	logic signed [TW-1:0]  nxt_c, fxt_c, nyt_c, fyt_c, tn_c, tf_c;
	logic                  hit_c;
	logic [1:0]            nx_c, ny_c;
	logic                  hit_s1, hit_s2;
	logic [ETW-1:0]        tn_s1, tn_s2;
	logic [1:0]            nx_s1, ny_s1, nx_s2, ny_s2;
	logic signed [CW-1:0]  px_s1, py_s1, vx_s1, vy_s1, px_s2, py_s2, vx_s2, vy_s2;
	logic signed [DXW-1:0] dx_s1, dy_s1;
	logic [STW-1:0]        remt_c;
	logic [CW-1:0]         mvx_c, mvy_c;
	logic signed [PW-1:0]  mcx_s2, mcy_s2;
	logic [AW-1:0]         axp_s2, ayp_s2;
	logic signed [XW-1:0]  csx_c, csy_c, nvx_c, nvy_c;
	res_t                  res_c, res_s3;

	function automatic logic signed [TW-1:0] lane_time(lane_t l);
		logic [QW-1:0]        q;
		logic signed [TW-1:0] m;
		q = l.ovf ? {QW{1'b1}} : l.num;
		m = {2'b00, q};
		if (l.inf) return l.neg ? -TMAX : TMAX;
		return l.neg ? -m : m;
	endfunction

	function automatic logic signed [CW-1:0] sat(logic signed [XW-1:0] v);
		if (v[XW-1:CW-1] == '0 || v[XW-1:CW-1] == '1) return v[CW-1:0];
		return v[XW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
	endfunction

	assign rdy3     = !vld_s3 || out_ready;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		for (int i = 0; i < LANES; i++) t_c[i] = lane_time(in_lanes[i]);
		nxt_c = (t_c[LN_AX] > t_c[LN_BX]) ? t_c[LN_BX] : t_c[LN_AX];
		fxt_c = (t_c[LN_AX] > t_c[LN_BX]) ? t_c[LN_AX] : t_c[LN_BX];
		nyt_c = (t_c[LN_AY] > t_c[LN_BY]) ? t_c[LN_BY] : t_c[LN_AY];
		fyt_c = (t_c[LN_AY] > t_c[LN_BY]) ? t_c[LN_AY] : t_c[LN_BY];
		tn_c  = (nxt_c > nyt_c) ? nxt_c : nyt_c;
		tf_c  = (fxt_c < fyt_c) ? fxt_c : fyt_c;
		hit_c = !in_side.miss && !(nxt_c > fyt_c || nyt_c > fxt_c)
			&& !tf_c[TW-1] && !tn_c[TW-1] && (tn_c < $signed({3'b000, ONE_T}));
		nx_c = NRM_NONE;
		ny_c = NRM_NONE;
		if (hit_c && nxt_c > nyt_c) nx_c = in_side.dx[DXW-1] ? NRM_POS : NRM_NEG;
		else if (hit_c && nxt_c < nyt_c) ny_c = in_side.dy[DXW-1] ? NRM_POS : NRM_NEG;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			hit_s1 <= hit_c;
			tn_s1  <= hit_c ? tn_c[ETW-1:0] : '0;
			nx_s1  <= nx_c;
			ny_s1  <= ny_c;
			px_s1  <= in_side.px;
			py_s1  <= in_side.py;
			vx_s1  <= in_side.vx;
			vy_s1  <= in_side.vy;
			dx_s1  <= in_side.dx;
			dy_s1  <= in_side.dy;
		end
	end

	always_comb begin
		remt_c = ONE_T - {1'b0, tn_s1};
		mvx_c  = vx_s1[CW-1] ? CW'(-vx_s1) : vx_s1;
		mvy_c  = vy_s1[CW-1] ? CW'(-vy_s1) : vy_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			mcx_s2 <= PW'($signed({1'b0, tn_s1})) * PW'(dx_s1);
			mcy_s2 <= PW'($signed({1'b0, tn_s1})) * PW'(dy_s1);
			axp_s2 <= AW'(mvx_c) * AW'(remt_c);
			ayp_s2 <= AW'(mvy_c) * AW'(remt_c);
			hit_s2 <= hit_s1;
			tn_s2  <= tn_s1;
			nx_s2  <= nx_s1;
			ny_s2  <= ny_s1;
			px_s2  <= px_s1;
			py_s2  <= py_s1;
			vx_s2  <= vx_s1;
			vy_s2  <= vy_s1;
		end
	end

	always_comb begin
		csx_c = XW'(px_s2) + XW'($signed(mcx_s2[PW-1:FB]));
		csy_c = XW'(py_s2) + XW'($signed(mcy_s2[PW-1:FB]));
		nvx_c = XW'(vx_s2);
		nvy_c = XW'(vy_s2);
		if (nx_s2 == NRM_POS) nvx_c = XW'(vx_s2) + $signed({2'b00, axp_s2[AW-1:FB]});
		if (nx_s2 == NRM_NEG) nvx_c = XW'(vx_s2) - $signed({2'b00, axp_s2[AW-1:FB]});
		if (ny_s2 == NRM_POS) nvy_c = XW'(vy_s2) + $signed({2'b00, ayp_s2[AW-1:FB]});
		if (ny_s2 == NRM_NEG) nvy_c = XW'(vy_s2) - $signed({2'b00, ayp_s2[AW-1:FB]});
		res_c.hit  = hit_s2;
		res_c.et   = tn_s2;
		res_c.cx   = hit_s2 ? sat(csx_c) : '0;
		res_c.cy   = hit_s2 ? sat(csy_c) : '0;
		res_c.nx   = nx_s2;
		res_c.ny   = ny_s2;
		res_c.side = {nx_s2 == NRM_POS, ny_s2 == NRM_NEG, nx_s2 == NRM_NEG, ny_s2 == NRM_POS};
		res_c.nvx  = sat(nvx_c);
		res_c.nvy  = sat(nvy_c);
	end

	always_ff @(posedge clk) begin
		if (rdy3) res_s3 <= res_c;
	end

	assign out_valid = vld_s3;
	assign out_res   = res_s3;

endmodule
`default_nettype wire

// File: rtl/core/swept_aabb_collision_resolve.sv
// Top level of the swept box against fixed box collision pipeline.
// Takes one box pair per cycle unless backpressure fills the pipeline and returns one
// result per pair, in order; the depth is set by the 18-stage restoring divider that works
// out the four slab entry and exit times side by side, with two setup stages before it and
// three merge, multiply and saturate stages after it. Every stage holds its item under
// backpressure and fills bubbles, so input flows while a result waits until stages fill.
// Slab times clamp at (2^18-1)/2^16 of a step; only times in the step reach a result.
`timescale 1ns / 1ps
`default_nettype none
module swept_aabb_collision_resolve (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// mover_pos_x, mover_pos_y, mover_size_x, mover_size_y, mover_vel_x, mover_vel_y,
	// step_time, obstacle_pos_x, obstacle_pos_y, obstacle_size_x, obstacle_size_y, pad
	input  wire logic [sacr_pkg::IN_W-1:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// hit, entry_time, contact_x, contact_y, normal_x, normal_y, side_mask,
	// new_vel_x, new_vel_y, pad
	output logic [sacr_pkg::OUT_W-1:0] m_axis_tdata
);
	import sacr_pkg::*;

	in_t    in_w;
	lanes_t f_lanes, d_lanes;
	side_t  f_side, d_side;
	logic   f_valid, f_ready, d_valid, d_ready;
	res_t   res_w;

	always_comb begin
		in_w.px  = s_axis_tdata[31:0];
		in_w.py  = s_axis_tdata[63:32];
		in_w.msx = s_axis_tdata[94:64];
		in_w.msy = s_axis_tdata[125:95];
		in_w.vx  = s_axis_tdata[157:126];
		in_w.vy  = s_axis_tdata[189:158];
		in_w.st  = s_axis_tdata[206:190];
		in_w.ox  = s_axis_tdata[238:207];
		in_w.oy  = s_axis_tdata[270:239];
		in_w.osx = s_axis_tdata[301:271];
		in_w.osy = s_axis_tdata[332:302];
	end

	sacr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_w),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_lanes (f_lanes),
		.out_side  (f_side)
	);

	sacr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_lanes  (f_lanes),
		.in_side   (f_side),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.out_lanes (d_lanes),
		.out_side  (d_side)
	);

	sacr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d_valid),
		.in_ready  (d_ready),
		.in_lanes  (d_lanes),
		.in_side   (d_side),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res_w)
	);

	assign m_axis_tdata = {7'b0, res_w.nvy, res_w.nvx, res_w.side, res_w.ny, res_w.nx,
		res_w.cy, res_w.cx, res_w.et, res_w.hit};

endmodule
`default_nettype wire

// File: rtl/core/sacr_chk.sv
// Port checker for the collision pipeline and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sacr_chk (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [159:0] m_axis_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped under backpressure");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[88:1] == '0)
		else $error("miss result carries contact data");

	a_side: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[88] == (m_axis_tdata[82:81] == 2'b01))
			&& (m_axis_tdata[86] == (m_axis_tdata[82:81] == 2'b11))
			&& (m_axis_tdata[85] == (m_axis_tdata[84:83] == 2'b01))
			&& (m_axis_tdata[87] == (m_axis_tdata[84:83] == 2'b11)))
		else $error("side mask disagrees with normal");

	a_one_axis: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[82:81] == 2'b00 || m_axis_tdata[84:83] == 2'b00)
		else $error("normal on both axes");

endmodule

bind swept_aabb_collision_resolve sacr_chk u_sacr_chk (.*);
`default_nettype wire

// File: sim/swept_aabb_collision_checker.sv
// Predicts and checks the results of the swept box collision pipeline.
`timescale 1ns / 1ps
module swept_aabb_collision_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	input  logic                        s_axis_tready,
	input  logic [sacr_pkg::IN_W-1:0]   s_axis_tdata,
	input  logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	input  logic [sacr_pkg::OUT_W-1:0]  m_axis_tdata,
	output int                          errors,
	output int                          pending
);
	localparam longint T_INF = 64'sd1 <<< 62;
	localparam longint ONE = 64'sd1 <<< sacr_pkg::FB;

	logic [sacr_pkg::OUT_W-1:0] result_q[$];

	function automatic longint mag(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint floor_frac(input longint v);
		if (v >= 0)
			return v >>> sacr_pkg::FB;
		return -((-v + ONE - 1) >>> sacr_pkg::FB);
	endfunction

	function automatic longint clamp_coord(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint slab_ratio(input longint n, input longint d);
		longint q;
		q = (mag(n) << sacr_pkg::FB) / (2 * mag(d));
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	function automatic bit slab_bounds(input longint p, input longint d, input longint op,
			input longint s, output longint tn, output longint tf);
		longint a2, b2, n, f, t;
		tn = 0;
		tf = 0;
		a2 = 2 * op - s - 2 * p;
		b2 = 2 * op + s - 2 * p;
		if (d == 0) begin
			if (a2 == 0 || b2 == 0)
				return 0;
			n = a2 < 0 ? -T_INF : T_INF;
			f = b2 < 0 ? -T_INF : T_INF;
		end else begin
			n = slab_ratio(a2, d);
			f = slab_ratio(b2, d);
		end
		if (n > f) begin
			t = n;
			n = f;
			f = t;
		end
		tn = n;
		tf = f;
		return 1;
	endfunction

	function automatic logic [sacr_pkg::OUT_W-1:0] resolve_pair(
			input logic [sacr_pkg::IN_W-1:0] d);
		longint px, py, msx, msy, vx, vy, st, ox, oy, osx, osy;
		longint dx, dy, nxt, nyt, fxt, fyt, tn, tf, cx, cy, rem, ax, ay, nvx, nvy;
		int nx, ny;
		bit hit;
		logic [3:0] side;
		logic [sacr_pkg::OUT_W-1:0] r;
		px = longint'($signed(d[31:0]));
		py = longint'($signed(d[63:32]));
		msx = longint'(d[94:64]);
		msy = longint'(d[125:95]);
		vx = longint'($signed(d[157:126]));
		vy = longint'($signed(d[189:158]));
		st = longint'(d[206:190]);
		ox = longint'($signed(d[238:207]));
		oy = longint'($signed(d[270:239]));
		osx = longint'(d[301:271]);
		osy = longint'(d[332:302]);
		dx = floor_frac(vx * st);
		dy = floor_frac(vy * st);
		hit = 0;
		nx = 0;
		ny = 0;
		tn = 0;
		if (vx != 0 || vy != 0)
			if (slab_bounds(px, dx, ox, osx + msx, nxt, fxt))
				if (slab_bounds(py, dy, oy, osy + msy, nyt, fyt))
					if (!(nxt > fyt || nyt > fxt)) begin
						tn = nxt > nyt ? nxt : nyt;
						tf = fxt < fyt ? fxt : fyt;
						hit = (tf >= 0) && (tn >= 0) && (tn < ONE);
					end
		r = '0;
		if (!hit) begin
			r[120:89] = vx[31:0];
			r[152:121] = vy[31:0];
			return r;
		end
		if (nxt > nyt)
			nx = dx < 0 ? 1 : -1;
		else if (nxt < nyt)
			ny = dy < 0 ? 1 : -1;
		cx = clamp_coord(px + floor_frac(tn * dx));
		cy = clamp_coord(py + floor_frac(tn * dy));
		rem = ONE - tn;
		ax = (mag(vx) * rem) >>> sacr_pkg::FB;
		ay = (mag(vy) * rem) >>> sacr_pkg::FB;
		nvx = clamp_coord(vx + nx * ax);
		nvy = clamp_coord(vy + ny * ay);
		side = {nx > 0, ny < 0, nx < 0, ny > 0};
		r[0] = 1'b1;
		r[16:1] = tn[15:0];
		r[48:17] = cx[31:0];
		r[80:49] = cy[31:0];
		r[82:81] = 2'(nx);
		r[84:83] = 2'(ny);
		r[88:85] = side;
		r[120:89] = nvx[31:0];
		r[152:121] = nvy[31:0];
		return r;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			errors++;
			if (errors <= 10)
				$display("%t mismatch %s: expected %0d actual %0d", $realtime, name, want, got);
		end
	endtask

	assign pending = result_q.size();

	always @(posedge clk or negedge arst_n) begin
		logic [sacr_pkg::OUT_W-1:0] e;
		if (!arst_n) begin
			errors <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				result_q.push_back(resolve_pair(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (result_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%t result with no item outstanding", $realtime);
				end else begin
					e = result_q.pop_front();
					check_field("hit", longint'(e[0]), longint'(m_axis_tdata[0]));
					check_field("entry_time", longint'(e[16:1]),
						longint'(m_axis_tdata[16:1]));
					check_field("contact_x", longint'($signed(e[48:17])),
						longint'($signed(m_axis_tdata[48:17])));
					check_field("contact_y", longint'($signed(e[80:49])),
						longint'($signed(m_axis_tdata[80:49])));
					check_field("normal_x", longint'(e[82:81]),
						longint'(m_axis_tdata[82:81]));
					check_field("normal_y", longint'(e[84:83]),
						longint'(m_axis_tdata[84:83]));
					check_field("side_mask", longint'(e[88:85]),
						longint'(m_axis_tdata[88:85]));
					check_field("new_vel_x", longint'($signed(e[120:89])),
						longint'($signed(m_axis_tdata[120:89])));
					check_field("new_vel_y", longint'($signed(e[152:121])),
						longint'($signed(m_axis_tdata[152:121])));
				end
			end
		end
	end
endmodule

// File: sim/tb_swept_aabb_collision_resolve.sv
// Stimulus and verdict for the swept box collision pipeline.
`timescale 1ns / 1ps
module tb_swept_aabb_collision_resolve;
	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [sacr_pkg::IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [sacr_pkg::OUT_W-1:0] m_axis_tdata;
	int errors, pending;
	int idle_pct = 0;
	int stall_pct = 0;

	always #6 clk = ~clk;

	swept_aabb_collision_resolve DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	swept_aabb_collision_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk)
		if (arst_n)
			m_axis_tready <= ($urandom_range(99) >= stall_pct);

	function automatic logic [sacr_pkg::IN_W-1:0] pack_pair(
			input logic [31:0] px, input logic [31:0] py,
			input logic [31:0] msx, input logic [31:0] msy,
			input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] st,
			input logic [31:0] ox, input logic [31:0] oy,
			input logic [31:0] osx, input logic [31:0] osy);
		return {3'b0, osy[30:0], osx[30:0], oy, ox, st[16:0], vy, vx, msy[30:0], msx[30:0],
			py, px};
	endfunction

	task automatic send_pair(input logic [sacr_pkg::IN_W-1:0] d);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [sacr_pkg::IN_W-1:0] random_pair();
		logic [31:0] px, py, ox, oy, vx, vy;
		logic [31:0] msx, msy, osx, osy;
		logic [31:0] st;
		int span;
		if ($urandom_range(9) < 2)
			return pack_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom);
		span = 1 << $urandom_range(26, 8);
		px = $urandom;
		py = $urandom;
		ox = px + $urandom_range(2 * span) - span;
		oy = py + $urandom_range(2 * span) - span;
		msx = $urandom_range(span);
		msy = $urandom_range(span);
		osx = $urandom_range(span);
		osy = $urandom_range(span);
		st = ($urandom_range(9) == 0) ? $urandom : $urandom_range(65536);
		vx = (ox - px) * $urandom_range(3) + $urandom_range(span / 4) - span / 8;
		vy = (oy - py) * $urandom_range(3) + $urandom_range(span / 4) - span / 8;
		case ($urandom_range(9))
			0: vx = 0;
			1: vy = 0;
			2: vy = vx;
			default: ;
		endcase
		return pack_pair(px, py, msx, msy, vx, vy, st, ox, oy, osx, osy);
	endfunction

	initial begin
		#50000000;
		$display("tb_swept_aabb_collision_resolve: errors");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		// zero velocity
		send_pair(pack_pair(0, 0, 32'h10000, 32'h10000, 0, 0, 32'h10000,
			32'h30000, 0, 32'h10000, 32'h10000));
		// head-on hit along x, then along y
		send_pair(pack_pair(0, 0, 32'h10000, 32'h10000, 32'h50000, 0, 32'h10000,
			32'h30000, 0, 32'h10000, 32'h10000));
		send_pair(pack_pair(0, 0, 32'h10000, 32'h10000, 0, 32'hFFFB0000, 32'h10000,
			0, 32'hFFFD0000, 32'h10000, 32'h10000));
		// zero step on one axis with the ray on the slab edge
		send_pair(pack_pair(0, 32'h10000, 32'h10000, 32'h10000, 32'h50000, 0, 32'h10000,
			32'h30000, 0, 32'h10000, 32'h10000));
		// corner entry
		send_pair(pack_pair(0, 0, 0, 0, 32'h140000, 32'h140000, 32'h10000,
			32'hA0000, 32'hA0000, 32'h20000, 32'h20000));
		send_pair(pack_pair(0, 0, 0, 0, 32'hFFEC0000, 32'h140000, 32'h10000,
			32'hFFF60000, 32'hA0000, 32'h20000, 32'h20000));
		// starting inside, and a zero step
		send_pair(pack_pair(0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000,
			0, 0, 32'h40000, 32'h40000));
		send_pair(pack_pair(0, 0, 32'h10000, 32'h10000, 32'h50000, 0, 0,
			32'h30000, 0, 32'h10000, 32'h10000));
		// step above one second and at the field maximum
		send_pair(pack_pair(0, 0, 32'h10000, 32'h10000, 32'h20000, 0, 32'h1FFFF,
			32'h30000, 0, 32'h10000, 32'h10000));
		send_pair(pack_pair(0, 0, 32'h10000, 32'h10000, 32'h7FFFFFFF, 32'h80000000,
			32'h10000, 32'h100000, 32'hFFF00000, 32'h10000, 32'h10000));
		// field extremes
		send_pair(pack_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h1FFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF));
		send_pair(pack_pair(32'h80000000, 32'h80000000, 0, 0, 32'h80000000, 32'h80000000,
			32'h10000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0));
		send_pair(pack_pair(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 32'h7FFFFFFF,
			32'h80000000, 32'h10000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h7FFFFFFF));
		send_pair(pack_pair(0, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h1FFFF,
			32'h40000000, 32'h40000000, 32'h7FFFFFFF, 32'h7FFFFFFF));
		send_pair(pack_pair('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
		send_pair(pack_pair(0, 0, 0, 0, 1, 0, 32'h10000, 0, 0, 0, 0));
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 67 : 35) : 0;
			stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 67 : 35) : 0;
			for (int i = 0; i < 375; i++)
				send_pair(random_pair());
			drain();
		end
		repeat (40) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb_swept_aabb_collision_resolve: clean");
		else
			$display("tb_swept_aabb_collision_resolve: errors");
		$finish;
	end
endmodule

// File: filelist.f
rtl/core/sacr_pkg.sv
rtl/core/sacr_front.sv
rtl/core/sacr_div.sv
rtl/core/sacr_back.sv
rtl/core/swept_aabb_collision_resolve.sv
rtl/core/sacr_chk.sv
sim/swept_aabb_collision_checker.sv
sim/tb_swept_aabb_collision_resolve.sv
